>>> rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Widths, register indexes and scale constants shared by the multi-turn
// encoder tracker and its divider.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int BYTE_W     = 8;
   localparam int EL_W       = 20;
   localparam int POS_W      = 18;
   localparam int POS15_W    = 15;
   localparam int TURN_W     = 32;
   localparam int ANG_W      = 25;
   localparam int TOT_W      = 64;
   localparam int SPD_W      = 48;
   localparam int NUM_W      = 48;
   localparam int DEN_W      = 22;
   localparam int STEP_W     = 20;
   localparam int KCONST_W   = 30;
   localparam int SCALE_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 192;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_KIND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET = 1'b1;

   // sensor kinds
   localparam logic KIND_18BIT = 1'b0;
   localparam logic KIND_15BIT = 1'b1;

   localparam logic signed [STEP_W-1:0] HALF18 = 20'sd131072;
   localparam logic signed [STEP_W-1:0] REV18  = 20'sd262144;
   localparam logic signed [STEP_W-1:0] HALF15 = 20'sd16384;
   localparam logic signed [STEP_W-1:0] REV15  = 20'sd32768;

   // q16.16 degrees per count
   localparam logic [SCALE_W-1:0] SCALE18 = 10'd90;
   localparam logic [SCALE_W-1:0] SCALE15 = 10'd720;

   // 360 * 1e6, and twice that for the 15-bit revolution
   localparam logic [KCONST_W-1:0] KSPD18 = 30'd360000000;
   localparam logic [KCONST_W-1:0] KSPD15 = 30'd720000000;

   localparam logic [SPD_W-1:0] SPD_MAX     = 48'h7FFF_FFFF_FFFF;
   localparam logic [SPD_W-1:0] SPD_NEG_MAG = 48'h8000_0000_0000;

endpackage

>>> rtl/multiturn_encoder_tracker.sv
// ----------------------------------------------------------------------------
// multiturn_encoder_tracker
// Multi-turn absolute encoder unwrap: position, turns, angles and speed.
// ----------------------------------------------------------------------------
// Each accepted frame beat is worked on alone: req_tready is high only while
// the block is idle. The speed quotient is formed by the 48-step restoring
// divider; with elapsed_us zero the division is skipped. The result sits in
// an output register, so the next frame is accepted while the previous
// result still waits on rsp_tready. csr writes are always taken and are
// only to be made while no frame is in flight.
// ----------------------------------------------------------------------------
module multiturn_encoder_tracker
   import mte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // byte_zero, byte_one, byte_two, byte_three, elapsed_us, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position, turns, angle_single, angle_total, speed, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]      csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UNPACK = 3'd1;
   localparam logic [2:0] S_MULT   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              kind_ff;
   logic [POS_W-1:0]  zero_offset_ff;
   logic [POS_W-1:0]  last_ff;
   logic [TURN_W-1:0] turns_ff, turns_in;

   logic [BYTE_W-1:0] b0_ff, b1_ff, b2_ff, b3_ff;
   logic [EL_W-1:0]   el_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [ANG_W-1:0]  single_ff;
   logic [POS_W-1:0]  mag_ff;
   logic              neg_ff;
   logic              zero_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [TOT_W-1:0]  total_ff;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [TURN_W-1:0] rsp_turns_ff;
   logic [ANG_W-1:0]  rsp_single_ff;
   logic [TOT_W-1:0]  rsp_total_ff;
   logic [SPD_W-1:0]  rsp_speed_ff;

   logic              accept;
   logic              out_load;

   logic [POS_W-1:0]        raw18, pos18;
   logic [POS15_W-1:0]      raw15, pos15;
   logic [POS_W-1:0]        pos_in;
   logic signed [STEP_W-1:0] diff, half, neg_half, rev, step_in, neg_step;
   logic [POS_W-1:0]        mag_in;
   logic [SCALE_W-1:0]      scale;
   logic [27:0]             single_prod;

   logic [KCONST_W-1:0]     kconst;
   logic [NUM_W-1:0]        num_in;
   logic [47:0]             t_ext, t360;
   logic [TOT_W-1:0]        total_in;

   logic                    div_start;
   logic                    div_done;
   logic [NUM_W-1:0]        quo;
   logic [SPD_W-1:0]        speed_in;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign div_start  = (state_ff == S_MULT) && !zero_ff;

   // unpack, offset and turn detection
   always_comb begin
      raw18    = {b2_ff[1:0], b1_ff, b0_ff};
      pos18    = raw18 - zero_offset_ff;
      raw15    = {b3_ff[6:0], b2_ff};
      pos15    = raw15 - zero_offset_ff[POS15_W-1:0];
      pos_in   = (kind_ff == KIND_15BIT) ? {3'b000, pos15} : pos18;
      half     = (kind_ff == KIND_15BIT) ? HALF15 : HALF18;
      rev      = (kind_ff == KIND_15BIT) ? REV15 : REV18;
      neg_half = -half;
      diff     = $signed({2'b00, pos_in}) - $signed({2'b00, last_ff});
      if (diff > half) begin
         step_in  = diff - rev;
         turns_in = turns_ff - 1'b1;
      end else if (diff < neg_half) begin
         step_in  = diff + rev;
         turns_in = turns_ff + 1'b1;
      end else begin
         step_in  = diff;
         turns_in = turns_ff;
      end
      neg_step    = -step_in;
      mag_in      = step_in[STEP_W-1] ? neg_step[POS_W-1:0] : step_in[POS_W-1:0];
      scale       = (kind_ff == KIND_15BIT) ? SCALE15 : SCALE18;
      single_prod = {10'b0, pos_in} * {18'b0, scale};
   end

   // speed numerator and total angle
   always_comb begin
      kconst   = (kind_ff == KIND_15BIT) ? KSPD15 : KSPD18;
      num_in   = {30'b0, mag_ff} * {18'b0, kconst};
      t_ext    = {{16{turns_ff[TURN_W-1]}}, turns_ff};
      t360     = (t_ext << 8) + (t_ext << 6) + (t_ext << 5) + (t_ext << 3);
      total_in = {t360, 16'b0} + {39'b0, single_ff};
   end

   // sign and saturation
   always_comb begin
      if (zero_ff) begin
         speed_in = '0;
      end else if (neg_ff) begin
         speed_in = (quo > SPD_NEG_MAG) ? SPD_NEG_MAG : quo;
         speed_in = -speed_in;
      end else begin
         speed_in = quo[NUM_W-1] ? SPD_MAX : quo;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_UNPACK;
         end
         S_UNPACK: state_in = S_MULT;
         S_MULT: begin
            state_in = zero_ff ? S_FINISH : S_DIV;
         end
         S_DIV: begin
            if (div_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   mte_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_in),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         kind_ff        <= KIND_18BIT;
         zero_offset_ff <= '0;
         last_ff        <= '0;
         turns_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SENSOR_KIND) begin
               kind_ff <= csr_data[0];
            end else if (csr_index == CSR_ZERO_OFFSET) begin
               zero_offset_ff <= csr_data;
            end
         end
         if (state_ff == S_UNPACK) begin
            last_ff  <= pos_in;
            turns_ff <= turns_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b0_ff <= req_tdata[7:0];
         b1_ff <= req_tdata[15:8];
         b2_ff <= req_tdata[23:16];
         b3_ff <= req_tdata[31:24];
         el_ff <= req_tdata[51:32];
      end
      if (state_ff == S_UNPACK) begin
         pos_ff    <= pos_in;
         single_ff <= single_prod[ANG_W-1:0];
         mag_ff    <= mag_in;
         neg_ff    <= step_in[STEP_W-1];
         zero_ff   <= (el_ff == '0);
         den_ff    <= (kind_ff == KIND_15BIT) ? {2'b00, el_ff} : {el_ff, 2'b00};
      end
      if (state_ff == S_MULT) begin
         total_ff <= total_in;
      end
      if (out_load) begin
         rsp_pos_ff    <= pos_ff;
         rsp_turns_ff  <= turns_ff;
         rsp_single_ff <= single_ff;
         rsp_total_ff  <= total_ff;
         rsp_speed_ff  <= speed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_speed_ff, rsp_total_ff, rsp_single_ff,
                        rsp_turns_ff, rsp_pos_ff};

endmodule

>>> rtl/mte_div.sv
// ----------------------------------------------------------------------------
// mte_div
// Restoring divider, one quotient bit per cycle, for the speed quotient.
// ----------------------------------------------------------------------------
module mte_div
   import mte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   trial_in;
   logic [DEN_W:0]   diff_in;
   logic             bit_in;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial_in = {rem_ff, quo_ff[NUM_W-1]};
      diff_in  = trial_in - {1'b0, den_ff};
      bit_in   = (trial_in >= {1'b0, den_ff});
      rem_in   = bit_in ? diff_in[DEN_W-1:0] : trial_in[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], bit_in};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> tb/sv/multiturn_encoder_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiturn_encoder_tracker_checker
// Watches the frame, result and csr channels of the encoder tracker. Every
// accepted frame is unwrapped by an in-bench model of the count unpacking,
// offset, turn detection and speed division, and the outcome is queued. Each
// accepted result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module multiturn_encoder_tracker_checker
   import mte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // byte_zero, byte_one, byte_two, byte_three, elapsed_us, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position, turns, angle_single, angle_total, speed, zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]      csr_data,
   output int                    fail_count,
   output int                    pending
);

   // packed from the top down, so position lands in the lowest bits
   typedef struct packed {
      logic signed [SPD_W-1:0]  speed;
      logic signed [TOT_W-1:0]  angle_total;
      logic        [ANG_W-1:0]  angle_single;
      logic signed [TURN_W-1:0] turns;
      logic        [POS_W-1:0]  position;
   } frame_result_type;

   localparam int RESULT_BITS = $bits(frame_result_type);

   logic                     cfg_kind;
   logic [POS_W-1:0]         cfg_offset;
   logic [POS_W-1:0]         last_pos;
   logic signed [TURN_W-1:0] turn_total;
   frame_result_type         tracked_frames[$];
   frame_result_type         want;
   frame_result_type         seen;
   int                       rsp_beats;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_beats  = 0;
   end

   function automatic frame_result_type unwrap_frame(input logic [REQ_DATA_W-1:0] beat);
      logic [BYTE_W-1:0]    b0, b1, b2, b3;
      logic [EL_W-1:0]      elapsed;
      logic [POS_W-1:0]     pos;
      logic [POS15_W-1:0]   pos15;
      logic [ANG_W-1:0]     single;
      int                   rev, half, step;
      longint unsigned      mag, num, den, quot;
      logic [63:0]          spd;
      frame_result_type     r;
      b0      = beat[7:0];
      b1      = beat[15:8];
      b2      = beat[23:16];
      b3      = beat[31:24];
      elapsed = beat[51:32];
      if (cfg_kind == KIND_18BIT) begin
         rev  = int'(REV18);
         half = int'(HALF18);
         pos  = {b2[1:0], b1, b0} - cfg_offset;
      end else begin
         rev   = int'(REV15);
         half  = int'(HALF15);
         pos15 = {b3[6:0], b2} - cfg_offset[POS15_W-1:0];
         pos   = {3'b000, pos15};
      end
      step = int'(pos) - int'(last_pos);
      if (step > half) begin
         turn_total = turn_total - 1;
         step       = step - rev;
      end else if (step < -half) begin
         turn_total = turn_total + 1;
         step       = step + rev;
      end
      last_pos = pos;
      single = (cfg_kind == KIND_18BIT) ? pos * SCALE18 : pos * SCALE15;
      if (elapsed == '0) begin
         spd = '0;
      end else begin
         mag = (step < 0) ? longint'(-step) : longint'(step);
         if (cfg_kind == KIND_18BIT) begin
            num = mag * longint'(KSPD18);
            den = longint'(elapsed) * 4;
         end else begin
            num = mag * longint'(KSPD15);
            den = longint'(elapsed);
         end
         quot = num / den;
         if (step < 0) begin
            if (quot > longint'(SPD_NEG_MAG)) quot = longint'(SPD_NEG_MAG);
            spd = 64'd0 - quot;
         end else begin
            if (quot > longint'(SPD_MAX)) quot = longint'(SPD_MAX);
            spd = quot;
         end
      end
      r.position     = pos;
      r.turns        = turn_total;
      r.angle_single = single;
      r.angle_total  = longint'(turn_total) * 64'sd23592960 + longint'(single);
      r.speed        = spd[SPD_W-1:0];
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
      $display("%0t result beat %0d %s: got %h, expected %h", $time, rsp_beats, what, got,
               exp_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_kind   = KIND_18BIT;
         cfg_offset = '0;
         last_pos   = '0;
         turn_total = '0;
         tracked_frames.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            seen = frame_result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (tracked_frames.size() == 0) begin
               report("with nothing pending", 64'(seen.position), '0);
            end else begin
               want = tracked_frames.pop_front();
               if (seen.position !== want.position)
                  report("position", 64'(seen.position), 64'(want.position));
               if (seen.turns !== want.turns)
                  report("turns", 64'(seen.turns), 64'(want.turns));
               if (seen.angle_single !== want.angle_single)
                  report("angle_single", 64'(seen.angle_single), 64'(want.angle_single));
               if (seen.angle_total !== want.angle_total)
                  report("angle_total", seen.angle_total, want.angle_total);
               if (seen.speed !== want.speed)
                  report("speed", 64'(seen.speed), 64'(want.speed));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SENSOR_KIND: cfg_kind   = csr_data[0];
               CSR_ZERO_OFFSET: cfg_offset = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) tracked_frames.push_back(unwrap_frame(req_tdata));
      end
      pending <= tracked_frames.size();
   end

endmodule

>>> tb/sv/multiturn_encoder_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiturn_encoder_tracker_tb
// Drives encoder frames through the tracker under both sensor kinds and
// zero offsets: a directed run over wraps, half-turn steps and elapsed time
// extremes, then rotating-shaft traffic with noise, bursty input and a
// stalling result side. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module multiturn_encoder_tracker_tb;
   import mte_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int PHASES       = 8;
   localparam int PHASE_FRAMES = 75;
   localparam int HOLD_AT      = 230;
   localparam int HOLD_CYCLES  = 1500;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [POS_W-1:0]      csr_data;
   int                    fail_count;
   int                    pending;

   int                    cycles;
   int                    burst_left;
   int unsigned           shaft;
   int                    rsp_seen;
   int                    run_len;
   int                    pick;
   logic                  cur_kind;

   multiturn_encoder_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   multiturn_encoder_tracker_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_frame(input logic [7:0] b0, b1, b2, b3,
                                                       input logic [EL_W-1:0] elapsed);
      return {4'b0000, elapsed, b3, b2, b1, b0};
   endfunction

   task automatic send_frame(input logic [REQ_DATA_W-1:0] beat);
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic kind, input logic [POS_W-1:0] offset);
      wait_drained();
      csr_write(CSR_SENSOR_KIND, {17'd0, kind});
      csr_write(CSR_ZERO_OFFSET, offset);
      cur_kind = kind;
   endtask

   // rotating shaft with occasional half-turn jumps and garbage frames
   task automatic send_shaft_frame();
      int               half;
      int               delta;
      int unsigned      mask;
      logic [EL_W-1:0]  elapsed;
      logic [7:0]       b0, b1, b2, b3;
      half = (cur_kind == KIND_18BIT) ? int'(HALF18) : int'(HALF15);
      mask = (cur_kind == KIND_18BIT) ? 32'h3FFFF : 32'h7FFF;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         delta = int'($urandom_range(0, 2000)) - 1000;
         shaft = (shaft + delta) & mask;
      end else if (pick < 85) begin
         delta = half + int'($urandom_range(0, 4)) - 2;
         if ($urandom_range(0, 1) == 1) delta = -delta;
         shaft = (shaft + delta) & mask;
      end else if (pick < 92) begin
         shaft = $urandom & mask;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75)      elapsed = EL_W'($urandom_range(500, 2000));
      else if (pick < 85) elapsed = EL_W'($urandom_range(0, 1000000));
      else if (pick < 92) elapsed = '0;
      else                elapsed = EL_W'($urandom_range(1, 3));
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      b3 = 8'($urandom);
      if (cur_kind == KIND_18BIT) begin
         b0      = shaft[7:0];
         b1      = shaft[15:8];
         b2[1:0] = shaft[17:16];
      end else begin
         b2      = shaft[7:0];
         b3[6:0] = shaft[14:8];
      end
      send_frame(pack_frame(b0, b1, b2, b3, elapsed));
   endtask

   // result side: random stalls, long ready stretches, one long hold-off
   initial begin
      rsp_tready = 1'b0;
      rsp_seen   = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_seen >= HOLD_AT && rsp_seen < HOLD_AT + 1000) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_seen = HOLD_AT + 1000;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               rsp_tready <= 1'b0;
               run_len = $urandom_range(1, 40);
            end else if (pick < 9) begin
               rsp_tready <= 1'b1;
               run_len = $urandom_range(1, 20);
            end else begin
               rsp_tready <= 1'b1;
               run_len = $urandom_range(100, 300);
            end
            repeat (run_len) begin
               @(posedge clock);
               if (rsp_tvalid && rsp_tready) rsp_seen++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SENSOR_KIND;
      csr_data   = '0;
      cycles     = 0;
      burst_left = 0;
      shaft      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 18-bit: wraps both ways, exact half-turn steps, elapsed extremes
      set_mode(KIND_18BIT, '0);
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd0));
      send_frame(pack_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 20'd1));
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd1000000));
      send_frame(pack_frame(8'h00, 8'h00, 8'h02, 8'h00, 20'd1000));
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd1000));
      send_frame(pack_frame(8'h01, 8'h00, 8'h02, 8'h00, 20'd1000));
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd1));
      send_frame(pack_frame(8'h40, 8'h0D, 8'h03, 8'h00, 20'd250));

      // 15-bit right after a large 18-bit position, offset beyond a revolution
      set_mode(KIND_15BIT, 18'h3FFFF);
      send_frame(pack_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 20'd1000));
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h80, 20'd0));
      send_frame(pack_frame(8'hFF, 8'hFF, 8'h00, 8'h40, 20'd1));
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd1000000));
      send_frame(pack_frame(8'h00, 8'h00, 8'h02, 8'h40, 20'd1000));

      set_mode(KIND_18BIT, 18'd131072);
      send_frame(pack_frame(8'h00, 8'h00, 8'h00, 8'h00, 20'd1));
      send_frame(pack_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 20'd20));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_mode(KIND_15BIT, '0);
            1:       set_mode(KIND_18BIT, 18'h3FFFF);
            2:       set_mode(KIND_15BIT, 18'd32768);
            3:       set_mode(KIND_18BIT, POS_W'($urandom));
            4:       set_mode(KIND_15BIT, 18'h3FFFF);
            5:       set_mode(KIND_18BIT, '0);
            6:       set_mode(KIND_15BIT, POS_W'($urandom));
            default: set_mode(KIND_18BIT, POS_W'($urandom));
         endcase
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (phase == 3 && n == 40) wait_drained();
            send_shaft_frame();
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
